FILE: rtl/mrf_pkg.sv
// Shared types and constants for the Modbus RTU request framer.
`default_nettype none

package mrf_pkg;

    localparam int unsigned FRAME_LEN = 8;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  SLAVE_MAX = 8'd247;
    localparam logic [7:0]  FUNC_MAX  = 8'd6;
    localparam logic [15:0] COUNT_MAX = 16'd125;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SLAVE = 2'd1,
        ST_BAD_FUNC  = 2'd2,
        ST_BAD_COUNT = 2'd3
    } status_t;

    typedef logic [$clog2(FRAME_LEN)-1:0] byte_idx_t;

    localparam byte_idx_t IDX_CRC_LO = byte_idx_t'(6);
    localparam byte_idx_t IDX_LAST   = byte_idx_t'(FRAME_LEN - 1);

endpackage

`default_nettype wire

FILE: rtl/mrf_crc_byte.sv
// One byte step of the CRC-16/MODBUS update (reflected polynomial).
`default_nettype none

module mrf_crc_byte (
    input  wire logic [15:0] crc,
    input  wire logic [7:0]  data,
    output logic [15:0]      crc_out
);
    import mrf_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

FILE: rtl/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer: request check, byte serializer and CRC.
//
// Usage:
//   A request (slave_address, function_number, register_start, register_count)
//   is transferred on the input channel when in_valid is high and in_stall is low.
//   The fields are checked at that edge. A good request produces eight frame
//   bytes on the output channel, one per cycle while out_stall is low: slave,
//   function, start high and low, count high and low, then the CRC-16/MODBUS
//   low and high bytes; is_last marks the eighth byte. A rejected request produces
//   one result with status 1, 2 or 3, frame_byte zero and is_last set.
//   The first result is offered the cycle after the request is taken. The CRC
//   is folded in one byte per cycle while out_stall is low, as the body bytes
//   leave, so the serializer sets the rate.
//   The next request is taken in the same cycle as the previous request's
//   last transfer, so frames follow back to back with no gap.
//   When the receiver holds out_stall, the current byte stays on the port and
//   the input channel stalls once a request is waiting.
//   Reset empties the block: out_valid falls and in_stall is low.
`default_nettype none

module modbus_rtu_request_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  slave_address,
    input  wire logic [7:0]  function_number,
    input  wire logic [15:0] register_start,
    input  wire logic [15:0] register_count,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             is_last,
    output logic [1:0]       status
);
    import mrf_pkg::*;

    logic        busy_reg, busy_next;
    byte_idx_t   idx_reg, idx_next;
    status_t     status_reg, status_next;
    logic [7:0]  slave_reg, slave_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;

    logic        in_take;
    logic        out_take;
    logic        last_byte;
    logic [7:0]  body_byte;
    logic [15:0] crc_step;
    status_t     check;

    assign last_byte = (status_reg != ST_OK) || (idx_reg == IDX_LAST);
    assign out_take  = busy_reg && !out_stall;
    assign in_stall  = busy_reg && !(out_take && last_byte);
    assign in_take   = in_valid && !in_stall;

    // Checks are made in order; the first failure decides the status.
    always_comb
    begin
        if (slave_address == 8'd0 || slave_address > SLAVE_MAX)
        begin
            check = ST_BAD_SLAVE;
        end
        else if (function_number == 8'd0 || function_number > FUNC_MAX)
        begin
            check = ST_BAD_FUNC;
        end
        else if (register_count == 16'd0 || register_count > COUNT_MAX)
        begin
            check = ST_BAD_COUNT;
        end
        else
        begin
            check = ST_OK;
        end
    end

    always_comb
    begin
        case (idx_reg)
            byte_idx_t'(0): body_byte = slave_reg;
            byte_idx_t'(1): body_byte = func_reg;
            byte_idx_t'(2): body_byte = start_reg[15:8];
            byte_idx_t'(3): body_byte = start_reg[7:0];
            byte_idx_t'(4): body_byte = count_reg[15:8];
            byte_idx_t'(5): body_byte = count_reg[7:0];
            byte_idx_t'(6): body_byte = crc_reg[7:0];
            default:        body_byte = crc_reg[15:8];
        endcase
    end

    mrf_crc_byte u_crc (
        .crc     (crc_reg),
        .data    (body_byte),
        .crc_out (crc_step)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        slave_next  = slave_reg;
        func_next   = func_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;

        if (out_take)
        begin
            idx_next = idx_reg + byte_idx_t'(1);
            // The CRC only covers the six body bytes.
            if (idx_reg < IDX_CRC_LO)
            begin
                crc_next = crc_step;
            end
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
        end

        if (in_take)
        begin
            busy_next   = 1'b1;
            idx_next    = '0;
            status_next = check;
            slave_next  = slave_address;
            func_next   = function_number;
            start_next  = register_start;
            count_next  = register_count;
            crc_next    = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slave_reg <= slave_next;
        func_reg  <= func_next;
        start_reg <= start_next;
        count_reg <= count_next;
        crc_reg   <= crc_next;
    end

    assign out_valid  = busy_reg;
    assign frame_byte = (status_reg == ST_OK) ? body_byte : 8'd0;
    assign is_last    = last_byte;
    assign status     = status_reg;

endmodule

`default_nettype wire
